// ----- design/fslc_pkg.sv -----
// Package for the first-seen label compactor: item types and fixed widths.
// No dependencies; used by every module of the block and by the checker.
package fslc_pkg;

    localparam int LABEL_W = 32;
    localparam int DENSE_W = 8;

    // One pixel item on the input channel
    typedef struct packed {
        logic signed [LABEL_W-1:0] label_in;
        logic                      frame_start;
    } in_item_t;

    // One result item on the output channel
    typedef struct packed {
        logic [DENSE_W-1:0] dense_label;
        logic               overflow;
    } out_item_t;

endpackage

// ----- design/fslc_cam.sv -----
// Content-addressed label table: parallel compare, one-hot encode and insert.
// Depends on fslc_pkg for the result item type and field widths.
module fslc_cam #(
    parameter int ENTRIES = 255
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [fslc_pkg::LABEL_W-1:0]  key,
    input  logic                          start,
    input  logic                          commit,
    output fslc_pkg::out_item_t           result
);

    localparam int FILL_W = $clog2(ENTRIES + 1);
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [fslc_pkg::LABEL_W-1:0] keys_reg [ENTRIES];
    logic [ENTRIES-1:0]           valid_reg;
    logic [ENTRIES-1:0]           valid_next;
    logic [FILL_W-1:0]            fill_reg;
    logic [FILL_W-1:0]            fill_next;

    logic [ENTRIES-1:0]           eff_valid;
    logic [FILL_W-1:0]            eff_fill;
    logic [ENTRIES-1:0]           match;
    logic [ENTRIES-1:0]           slot_oh;
    logic [fslc_pkg::DENSE_W-1:0] hit_dense;
    logic [IDX_W-1:0]             slot;
    logic                         is_bg;
    logic                         hit;
    logic                         full;
    logic                         insert;

    // Frame start empties the table before this item looks it up
    assign eff_valid = start ? '0 : valid_reg;
    assign eff_fill  = start ? '0 : fill_reg;

    // Compare against every entry; stored keys are unique so match is one-hot
    always_comb
    begin
        hit_dense = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i]   = eff_valid[i] && (keys_reg[i] == key);
            slot_oh[i] = (eff_fill == FILL_W'(i));
            hit_dense  = hit_dense | (match[i] ? fslc_pkg::DENSE_W'(i + 1) : '0);
        end
    end

    assign is_bg  = (key == '0);
    assign hit    = |match;
    assign full   = (eff_fill == FILL_W'(ENTRIES));
    assign insert = !is_bg && !hit && !full;
    assign slot   = eff_fill[IDX_W-1:0];

    // Result selection
    always_comb
    begin
        result = '0;
        priority if (is_bg)
        begin
            result.dense_label = '0;
        end
        else if (hit)
        begin
            result.dense_label = hit_dense;
        end
        else if (!full)
        begin
            result.dense_label = fslc_pkg::DENSE_W'(eff_fill) + fslc_pkg::DENSE_W'(1);
        end
        else
        begin
            result.overflow = 1'b1;
        end
    end

    assign valid_next = eff_valid | (insert ? slot_oh : '0);
    assign fill_next  = eff_fill + FILL_W'(insert);

    // Table control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fill_reg  <= '0;
        end
        else if (commit)
        begin
            valid_reg <= valid_next;
            fill_reg  <= fill_next;
        end
    end

    // Stored keys, written only at the next free slot
    always_ff @(posedge clk)
    begin
        if (commit && insert)
        begin
            keys_reg[slot] <= key;
        end
    end

endmodule

// ----- design/first_seen_label_compactor_unit.sv -----
// Top level of the first-seen label compactor: input register, table, result register.
// Depends on fslc_pkg and fslc_cam.
//
//  channel | valid     | stall     | payload                     | dir
//  --------+-----------+-----------+-----------------------------+-----
//  pixel   | pix_valid | pix_stall | pix (label_in, frame_start) | in
//  label   | lbl_valid | lbl_stall | lbl (dense_label, overflow) | out
//
// One item per clock sustained unless lbl_stall holds the result register.
// The table lookup, one-hot encode and insert sit between the input and result registers.
// Reset empties the table at once (valid bits and fill count); no clearing pass.
// A stalled result holds; one more item waits in the input register meanwhile.
module first_seen_label_compactor_unit #(
    parameter int TABLE_ENTRIES = 255
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pix_valid,
    output logic                 pix_stall,
    input  fslc_pkg::in_item_t   pix,
    output logic                 lbl_valid,
    input  logic                 lbl_stall,
    output fslc_pkg::out_item_t  lbl
);

    logic                         a_valid_reg;
    logic                         a_valid_next;
    fslc_pkg::in_item_t           a_item_reg;
    logic                         o_valid_reg;
    logic                         o_valid_next;
    fslc_pkg::out_item_t          o_item_reg;
    fslc_pkg::out_item_t          cam_result;
    logic [fslc_pkg::LABEL_W-1:0] a_key;
    logic                         a_move;
    logic                         pix_take;
    logic                         commit;

    // Stage advance: result register is free or being taken
    assign a_move    = !o_valid_reg || !lbl_stall;
    assign pix_stall = a_valid_reg && !a_move;
    assign pix_take  = pix_valid && !pix_stall;
    assign commit    = a_valid_reg && a_move;
    assign a_key     = a_item_reg.label_in;

    assign a_valid_next = pix_take ? 1'b1 : (a_move ? 1'b0 : a_valid_reg);
    assign o_valid_next = a_move ? a_valid_reg : o_valid_reg;

    fslc_cam #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_cam (
        .clk    (clk),
        .rst_n  (rst_n),
        .key    (a_key),
        .start  (a_item_reg.frame_start),
        .commit (commit),
        .result (cam_result)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (pix_take)
        begin
            a_item_reg <= pix;
        end
        if (commit)
        begin
            o_item_reg <= cam_result;
        end
    end

    assign lbl_valid = o_valid_reg;
    assign lbl       = o_item_reg;

endmodule

// ----- design/fslc_chk.sv -----
// Port-level checker for the first-seen label compactor, bound to the top level.
// Depends on fslc_pkg and first_seen_label_compactor_unit.
module fslc_chk (
    input logic                clk,
    input logic                rst_n,
    input logic                pix_valid,
    input logic                pix_stall,
    input fslc_pkg::in_item_t  pix,
    input logic                lbl_valid,
    input logic                lbl_stall,
    input fslc_pkg::out_item_t lbl
);

    // Overflow never comes with a nonzero label
    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (lbl_valid && lbl.overflow) |-> (lbl.dense_label == '0))
        else $error("overflow item carries nonzero label");

    // Input only backs up when the output is full and stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> (lbl_valid && lbl_stall))
        else $error("input stalled without output backpressure");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (lbl_valid && lbl_stall) |=> (lbl_valid && $stable(lbl)))
        else $error("stalled result changed");

    // First nonzero label of a frame is numbered one
    a_first_one: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && !pix_stall && pix.frame_start && (pix.label_in != '0))
        ##1 (!lbl_valid || !lbl_stall)
        |=> (lbl_valid && (lbl.dense_label == 8'd1) && !lbl.overflow))
        else $error("first label of frame not numbered one");

    // Background stays background
    a_bg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && !pix_stall && (pix.label_in == '0))
        ##1 (!lbl_valid || !lbl_stall)
        |=> (lbl_valid && (lbl.dense_label == '0) && !lbl.overflow))
        else $error("background pixel gave nonzero result");

endmodule

bind first_seen_label_compactor_unit fslc_chk u_fslc_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .lbl_valid (lbl_valid),
    .lbl_stall (lbl_stall),
    .lbl       (lbl)
);

// ----- dv/tb_first_seen_label_compactor_unit.sv -----
// Testbench for first_seen_label_compactor_unit: random pixel frames with stalls on both sides.
// A scoreboard class predicts dense labels and overflow; depends on fslc_pkg and the top level.
`timescale 1ns / 1ps

module tb_first_seen_label_compactor_unit;

    localparam int TABLE_ENTRIES  = 255;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int FLOOD_ITEMS    = 30;
    localparam int RANDOM_ITEMS   = 1035;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HALF} stall_mode_t;

    // Scoreboard: keeps its own label table and the queue of expected label items
    class label_scoreboard;
        logic [fslc_pkg::LABEL_W-1:0] seen_key [TABLE_ENTRIES];
        bit                           key_used [TABLE_ENTRIES];
        bit [8:0]                     next_num;
        fslc_pkg::out_item_t          expected_q [$];
        int                           errors;

        function new();
            foreach (key_used[i]) key_used[i] = 1'b0;
            next_num = 9'd1;
            errors   = 0;
        endfunction

        // Predict the label item for one accepted pixel
        function void note_pixel(fslc_pkg::in_item_t it);
            logic [fslc_pkg::LABEL_W-1:0] key;
            fslc_pkg::out_item_t          res;
            bit                           hit;
            key = it.label_in;
            res = '0;
            hit = 1'b0;
            if (it.frame_start)
            begin
                foreach (key_used[i]) key_used[i] = 1'b0;
                next_num = 9'd1;
            end
            if (key != '0)
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (!hit && key_used[i] && seen_key[i] == key)
                    begin
                        res.dense_label = fslc_pkg::DENSE_W'(i + 1);
                        hit = 1'b1;
                    end
                end
                if (!hit)
                begin
                    if (next_num <= TABLE_ENTRIES)
                    begin
                        seen_key[next_num - 1] = key;
                        key_used[next_num - 1] = 1'b1;
                        res.dense_label = next_num[fslc_pkg::DENSE_W-1:0];
                        next_num = next_num + 9'd1;
                    end
                    else
                        res.overflow = 1'b1;
                end
            end
            expected_q.push_back(res);
        endfunction

        // Compare one accepted label item with the oldest prediction
        function void check_label(fslc_pkg::out_item_t got);
            fslc_pkg::out_item_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected label item: dense_label %0d overflow %0b",
                       got.dense_label, got.overflow);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.dense_label !== want.dense_label)
            begin
                $error("dense_label: expected %0d, got %0d", want.dense_label, got.dense_label);
                errors++;
            end
            if (got.overflow !== want.overflow)
            begin
                $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                pix_valid = 1'b0;
    logic                pix_stall;
    fslc_pkg::in_item_t  pix       = '0;
    logic                lbl_valid;
    logic                lbl_stall = 1'b0;
    fslc_pkg::out_item_t lbl;

    label_scoreboard sb;
    bit hold_req    = 1'b0;
    int burst_left  = 0;
    int idle_cycles = 0;

    first_seen_label_compactor_unit #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_valid(pix_valid),
        .pix_stall(pix_stall),
        .pix      (pix),
        .lbl_valid(lbl_valid),
        .lbl_stall(lbl_stall),
        .lbl      (lbl)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic fslc_pkg::in_item_t make_pixel(logic [fslc_pkg::LABEL_W-1:0] label,
                                                      bit fs);
        fslc_pkg::in_item_t p;
        p.label_in    = label;
        p.frame_start = fs;
        return p;
    endfunction

    // Mix of extremes, small positive, small negative and full-range labels
    function automatic logic [fslc_pkg::LABEL_W-1:0] random_label();
        int r;
        r = $urandom_range(0, 7);
        case (r)
            0: return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1: return ($urandom_range(0, 1)) ? 32'hFFFF_FFFF : 32'h0000_0001;
            2, 3: return $urandom_range(1, 400);
            4: return -$urandom_range(1, 400);
            default: return $urandom();
        endcase
    endfunction

    // Hold the pixel item until it is taken; caller runs just after a rising edge
    task automatic send_pixel(fslc_pkg::in_item_t it);
        pix       <= it;
        pix_valid <= 1'b1;
        do
            @(posedge clk);
        while (pix_stall);
        sb.note_pixel(it);
    endtask

    // Sender works in bursts with random gaps in between
    task automatic offer_pixel(fslc_pkg::in_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                pix_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        send_pixel(it);
    endtask

    // Stop offering until every predicted label item has come back
    task automatic wait_for_drain();
        pix_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
    endtask

    // Receiver holds off for a long stretch while the sender keeps going
    task automatic hold_and_flood(inout int sent);
        hold_req = 1'b1;
        repeat (FLOOD_ITEMS) send_pixel(make_pixel(random_label(), 1'b0));
        burst_left = 0;
        sent += FLOOD_ITEMS;
    endtask

    // One frame: a big one overruns the table, a small one repeats a few labels
    task automatic play_frame(input bit big, inout int sent);
        logic [fslc_pkg::LABEL_W-1:0] pool [$];
        logic [fslc_pkg::LABEL_W-1:0] label;
        int                           len;
        int                           pool_n;
        int                           r;
        bit                           start;
        start = big || ($urandom_range(0, 5) != 0);
        if (big)
        begin
            len = TABLE_ENTRIES + 45;
            for (int n = 0; n < len; n++)
            begin
                if (n >= TABLE_ENTRIES + 10 && $urandom_range(0, 1))
                    label = pool[$urandom_range(0, pool.size() - 1)];
                else
                begin
                    label = $urandom();
                    if (label == '0)
                        label = 32'h0000_1234;
                    pool.push_back(label);
                end
                offer_pixel(make_pixel(label, start && n == 0));
            end
        end
        else
        begin
            len    = $urandom_range(4, 60);
            pool_n = $urandom_range(1, 12);
            repeat (pool_n)
            begin
                label = random_label();
                pool.push_back((label == '0) ? 32'h0000_0001 : label);
            end
            for (int n = 0; n < len; n++)
            begin
                r = $urandom_range(0, 19);
                if (r < 4)
                    label = '0;
                else if (r == 4)
                    label = random_label();
                else
                    label = pool[$urandom_range(0, pool_n - 1)];
                offer_pixel(make_pixel(label,
                            (start && n == 0) || ($urandom_range(0, 199) == 0)));
            end
        end
        sent += len;
    endtask

    // Receiver: checks label items and stalls on its own pattern
    initial
    begin : receiver
        stall_mode_t mode;
        int          seg_left;
        int          hold_left;
        mode      = STALL_NONE;
        seg_left  = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && lbl_valid && !lbl_stall)
                sb.check_label(lbl);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (seg_left == 0)
            begin
                mode     = stall_mode_t'($urandom_range(0, 3));
                seg_left = $urandom_range(4, 50);
            end
            seg_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                lbl_stall <= 1'b1;
            end
            else
            begin
                case (mode)
                    STALL_NONE:  lbl_stall <= 1'b0;
                    STALL_LIGHT: lbl_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: lbl_stall <= ($urandom_range(0, 3) != 0);
                    default:     lbl_stall <= $urandom_range(0, 1);
                endcase
            end
        end
    end

    // Watchdog: too long without any item moving ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (pix_valid && !pix_stall) || (lbl_valid && !lbl_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        int sent;
        bit flooded;
        bit paused;
        sent    = 0;
        flooded = 1'b0;
        paused  = 1'b0;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, repeats, frame start on background and on a label
        offer_pixel(make_pixel(32'h0000_0000, 1'b1));
        offer_pixel(make_pixel(32'h0000_0001, 1'b0));
        offer_pixel(make_pixel(32'h7FFF_FFFF, 1'b0));
        offer_pixel(make_pixel(32'h8000_0000, 1'b0));
        offer_pixel(make_pixel(32'hFFFF_FFFF, 1'b0));
        offer_pixel(make_pixel(32'h0000_0001, 1'b0));
        offer_pixel(make_pixel(32'h0000_0000, 1'b0));
        offer_pixel(make_pixel(32'h8000_0000, 1'b0));
        offer_pixel(make_pixel(32'h7FFF_FFFF, 1'b1));
        offer_pixel(make_pixel(32'h0000_0001, 1'b0));
        offer_pixel(make_pixel(32'h7FFF_FFFF, 1'b0));
        offer_pixel(make_pixel(32'h0000_0000, 1'b1));
        offer_pixel(make_pixel(32'h0000_0005, 1'b0));
        offer_pixel(make_pixel(32'h0000_0005, 1'b1));
        offer_pixel(make_pixel(32'hFFFF_FFFF, 1'b0));
        wait_for_drain();

        // Random frames; the first one fills the table past its end
        play_frame(1'b1, sent);
        while (sent < RANDOM_ITEMS)
        begin
            if (!flooded && sent > 500)
            begin
                hold_and_flood(sent);
                flooded = 1'b1;
            end
            if (!paused && sent > 800)
            begin
                wait_for_drain();
                paused = 1'b1;
            end
            play_frame($urandom_range(0, 11) == 0, sent);
        end

        // Let the last label items come back, then a few more cycles
        wait_for_drain();
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
